// ----- rtl/avp_pkg.sv -----
// ----------------------------------------------------------------------------
// avp_pkg: shared types and constants for average pooling with activation
// Request and result words, configuration codes, activation codes, control
// groups passed between the position counter, the lanes and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package avp_pkg;

    // sample format
    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 8;
    localparam int LANES     = 8;

    // configuration register width and index width
    localparam int DIM_W     = 6;
    localparam int CFG_IDX_W = 2;

    // parameter defaults
    localparam int AVP_POOL_SIZE      = 2;
    localparam int AVP_MAX_COLS       = 32;
    localparam int AVP_MAX_ROWS       = 32;
    localparam int AVP_CHANNEL_GROUPS = 4;

    // h-swish constants: 3.0 and 6.0 in the sample format
    localparam int HS_D_W = 11;
    localparam logic signed [DATA_W-1:0] HS_THREE = DATA_W'(3 << FRAC_BITS);
    localparam logic [HS_D_W-1:0]        HS_SIX   = HS_D_W'(6 << FRAC_BITS);
    // d / 6 as multiply by reciprocal, exact for d up to 6.0
    localparam int HS_Q_W     = 9;
    localparam int HS_MUL_W   = 27;
    localparam int HS_RCP_SH  = 16;
    localparam logic [HS_MUL_W-1:0] HS_RCP_MUL = HS_MUL_W'(10923);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUT_ROWS = 2'd0,
        CFG_OUT_COLS = 2'd1,
        CFG_CHANNELS = 2'd2,
        CFG_ACT_MODE = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_PASS   = 2'd0,
        ACT_RELU   = 2'd1,
        ACT_HSWISH = 2'd2
    } t_act_mode;

    typedef struct packed {
        logic signed [DATA_W-1:0] pix7;
        logic signed [DATA_W-1:0] pix6;
        logic signed [DATA_W-1:0] pix5;
        logic signed [DATA_W-1:0] pix4;
        logic signed [DATA_W-1:0] pix3;
        logic signed [DATA_W-1:0] pix2;
        logic signed [DATA_W-1:0] pix1;
        logic signed [DATA_W-1:0] pix0;
    } t_pix_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] res7;
        logic signed [DATA_W-1:0] res6;
        logic signed [DATA_W-1:0] res5;
        logic signed [DATA_W-1:0] res4;
        logic signed [DATA_W-1:0] res3;
        logic signed [DATA_W-1:0] res2;
        logic signed [DATA_W-1:0] res1;
        logic signed [DATA_W-1:0] res0;
        logic                     tile_end;
    } t_res_word;

    // what the position counter reports for the request being accepted
    typedef struct packed {
        logic             first;
        logic             emit;
        logic             last;
        logic [LANES-1:0] mask;
    } t_pos_info;

    // per-cycle control common to all lanes
    typedef struct packed {
        logic rd_en;
        logic adv;
        logic wr_en;
        logic first;
        logic use_fwd;
    } t_lane_ctl;

endpackage

`default_nettype wire

// ----- rtl/avg_pool_with_activation.sv -----
// ----------------------------------------------------------------------------
// avg_pool_with_activation: 2-D average pooling with ReLU / h-swish
// Eight channel lanes pool POOL_SIZE x POOL_SIZE windows per pixel word and
// apply the selected activation; one result word per completed window.
// ----------------------------------------------------------------------------
// a window's result goes from its last pixel request through accumulate,
//   average, gate and activate into the output register, raising o_out_valid
// throughput: one pixel request per cycle unless stalled; the lane pipeline and
//   the accumulator memory read and write one column entry every unstalled cycle
// input stall is raised only while a result waits in the output register
// reset: synchronous, active low; clears position counters, valid bits and
//   registers to out_rows 1, out_cols 1, channels 32, passthrough mode
// ----------------------------------------------------------------------------
`default_nettype none

module avg_pool_with_activation
    import avp_pkg::*;
#(
    parameter int POOL_SIZE      = AVP_POOL_SIZE,
    parameter int MAX_COLS       = AVP_MAX_COLS,
    parameter int MAX_ROWS       = AVP_MAX_ROWS,
    parameter int CHANNEL_GROUPS = AVP_CHANNEL_GROUPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel requests
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_pix_req             i_in_data,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_res_word            o_out_data,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // configuration registers
    logic [DIM_W-1:0] r_out_rows, r_out_cols, r_channels;
    t_act_mode        r_act_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_rows <= DIM_W'(1);
            r_out_cols <= DIM_W'(1);
            r_channels <= DIM_W'(32);
            r_act_mode <= ACT_PASS;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OUT_ROWS: r_out_rows <= i_cfg_data;
                CFG_OUT_COLS: r_out_cols <= i_cfg_data;
                CFG_CHANNELS: r_channels <= i_cfg_data;
                CFG_ACT_MODE: r_act_mode <= t_act_mode'(i_cfg_data[1:0]);
                default:      r_out_rows <= r_out_rows;
            endcase
        end
    end

    // the whole pipeline moves together unless a finished result is held
    logic adv, acc;
    logic r_out_vld;
    assign adv        = !(r_out_vld && i_out_stall);
    assign acc        = i_in_valid && adv;
    assign o_in_stall = !adv;

    // position counter
    logic [COL_W-1:0] pos_oc;
    t_pos_info        pos_info;

    avp_ctrl #(
        .POOL_SIZE      (POOL_SIZE),
        .MAX_COLS       (MAX_COLS),
        .MAX_ROWS       (MAX_ROWS),
        .CHANNEL_GROUPS (CHANNEL_GROUPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_out_rows (r_out_rows),
        .i_out_cols (r_out_cols),
        .i_channels (r_channels),
        .o_oc       (pos_oc),
        .o_info     (pos_info)
    );

    // stage 1: accumulate; stages 2..4 only carry window-end requests
    logic             r_s1_vld;
    t_pos_info        r_s1_info;
    logic [COL_W-1:0] r_s1_oc;
    logic             r_s2_vld, r_s3_vld, r_s4_vld;
    logic             r_s2_last, r_s3_last, r_s4_last;
    logic [LANES-1:0] r_s2_mask, r_s3_mask, r_s4_mask;

    // last accumulator write, forwarded to a read that missed it
    logic             r_fwd_vld;
    logic [COL_W-1:0] r_fwd_oc;

    t_lane_ctl lane_ctl;
    assign lane_ctl.rd_en   = acc;
    assign lane_ctl.adv     = adv;
    assign lane_ctl.wr_en   = r_s1_vld && adv;
    assign lane_ctl.first   = r_s1_info.first;
    assign lane_ctl.use_fwd = r_fwd_vld && (r_fwd_oc == r_s1_oc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld  <= i_in_valid;
            r_s2_vld  <= r_s1_vld && r_s1_info.emit;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_out_vld <= r_s4_vld;
            if (r_s1_vld) begin
                r_fwd_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_info <= pos_info;
            r_s1_oc   <= pos_oc;
        end
        if (lane_ctl.wr_en) begin
            r_fwd_oc <= r_s1_oc;
        end
        if (adv) begin
            r_s2_last <= r_s1_info.last;
            r_s2_mask <= r_s1_info.mask;
            r_s3_last <= r_s2_last;
            r_s3_mask <= r_s2_mask;
            r_s4_last <= r_s3_last;
            r_s4_mask <= r_s3_mask;
        end
    end

    // lanes
    logic signed [DATA_W-1:0] pix_w [LANES];
    logic signed [DATA_W-1:0] res_w [LANES];

    assign pix_w[0] = i_in_data.pix0;
    assign pix_w[1] = i_in_data.pix1;
    assign pix_w[2] = i_in_data.pix2;
    assign pix_w[3] = i_in_data.pix3;
    assign pix_w[4] = i_in_data.pix4;
    assign pix_w[5] = i_in_data.pix5;
    assign pix_w[6] = i_in_data.pix6;
    assign pix_w[7] = i_in_data.pix7;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        avp_lane #(
            .POOL_SIZE (POOL_SIZE),
            .MAX_COLS  (MAX_COLS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_ctl     (lane_ctl),
            .i_rd_addr (pos_oc),
            .i_wr_addr (r_s1_oc),
            .i_pix     (pix_w[k]),
            .i_mode    (r_act_mode),
            .i_keep    (r_s4_mask[k]),
            .o_res     (res_w[k])
        );
    end

    // merge lane results into the output register
    t_res_word r_out_data;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data.res0     <= res_w[0];
            r_out_data.res1     <= res_w[1];
            r_out_data.res2     <= res_w[2];
            r_out_data.res3     <= res_w[3];
            r_out_data.res4     <= res_w[4];
            r_out_data.res5     <= res_w[5];
            r_out_data.res6     <= res_w[6];
            r_out_data.res7     <= res_w[7];
            r_out_data.tile_end <= r_s4_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ----- rtl/avp_ctrl.sv -----
// ----------------------------------------------------------------------------
// avp_ctrl: window and tile position counter
// Tracks window column, pooled column, window row, pooled row and channel
// group; flags window start, window end, tile end and active lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module avp_ctrl
    import avp_pkg::*;
#(
    parameter int POOL_SIZE      = AVP_POOL_SIZE,
    parameter int MAX_COLS       = AVP_MAX_COLS,
    parameter int MAX_ROWS       = AVP_MAX_ROWS,
    parameter int CHANNEL_GROUPS = AVP_CHANNEL_GROUPS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_acc,
    input  logic [DIM_W-1:0]       i_out_rows,
    input  logic [DIM_W-1:0]       i_out_cols,
    input  logic [DIM_W-1:0]       i_channels,
    output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] o_oc,
    output t_pos_info              o_info
);

    localparam int WIN_W = $clog2(POOL_SIZE);
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int GRP_W = (CHANNEL_GROUPS > 1) ? $clog2(CHANNEL_GROUPS) : 1;
    localparam int LIDX_W = DIM_W + 1;

    logic [WIN_W-1:0] r_wc, n_wc, r_wr, n_wr;
    logic [COL_W-1:0] r_oc, n_oc;
    logic [ROW_W-1:0] r_orow, n_orow;
    logic [GRP_W-1:0] r_grp, n_grp;

    logic [DIM_W-1:0] rows, cols;
    logic             col_wrap, row_wrap;
    logic [WIN_W-1:0] ewc, ewr;
    logic [COL_W-1:0] eoc;
    logic [ROW_W-1:0] eorow;
    logic             wc_last, wr_last, oc_last, orow_last, grp_last;

    // clamp tile dimensions to 1..max
    always_comb begin
        if (i_out_cols == '0) begin
            cols = DIM_W'(1);
        end else if (i_out_cols > DIM_W'(MAX_COLS)) begin
            cols = DIM_W'(MAX_COLS);
        end else begin
            cols = i_out_cols;
        end
        if (i_out_rows == '0) begin
            rows = DIM_W'(1);
        end else if (i_out_rows > DIM_W'(MAX_ROWS)) begin
            rows = DIM_W'(MAX_ROWS);
        end else begin
            rows = i_out_rows;
        end
    end

    // positions beyond a shrunk tile restart at zero
    assign col_wrap = DIM_W'(r_oc) >= cols;
    assign row_wrap = DIM_W'(r_orow) >= rows;
    assign eoc      = col_wrap ? '0 : r_oc;
    assign ewc      = col_wrap ? '0 : r_wc;
    assign eorow    = row_wrap ? '0 : r_orow;
    assign ewr      = row_wrap ? '0 : r_wr;

    assign wc_last   = ewc == WIN_W'(POOL_SIZE - 1);
    assign wr_last   = ewr == WIN_W'(POOL_SIZE - 1);
    assign oc_last   = DIM_W'(eoc) == cols - DIM_W'(1);
    assign orow_last = DIM_W'(eorow) == rows - DIM_W'(1);
    assign grp_last  = r_grp == GRP_W'(CHANNEL_GROUPS - 1);

    always_comb begin
        n_wc   = ewc;
        n_oc   = eoc;
        n_wr   = ewr;
        n_orow = eorow;
        n_grp  = r_grp;
        if (!wc_last) begin
            n_wc = ewc + WIN_W'(1);
        end else begin
            n_wc = '0;
            if (!oc_last) begin
                n_oc = eoc + COL_W'(1);
            end else begin
                n_oc = '0;
                if (!wr_last) begin
                    n_wr = ewr + WIN_W'(1);
                end else begin
                    n_wr = '0;
                    if (!orow_last) begin
                        n_orow = eorow + ROW_W'(1);
                    end else begin
                        n_orow = '0;
                        n_grp  = grp_last ? '0 : r_grp + GRP_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc   <= '0;
            r_oc   <= '0;
            r_wr   <= '0;
            r_orow <= '0;
            r_grp  <= '0;
        end else if (i_acc) begin
            r_wc   <= n_wc;
            r_oc   <= n_oc;
            r_wr   <= n_wr;
            r_orow <= n_orow;
            r_grp  <= n_grp;
        end
    end

    assign o_oc = eoc;

    always_comb begin
        o_info.first = (ewc == '0) && (ewr == '0);
        o_info.emit  = wc_last && wr_last;
        o_info.last  = wc_last && wr_last && oc_last && orow_last && grp_last;
        for (int k = 0; k < LANES; k++) begin
            o_info.mask[k] = (LIDX_W'({r_grp, 3'b000}) + LIDX_W'(k)) <
                             LIDX_W'(i_channels);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/avp_lane.sv -----
// ----------------------------------------------------------------------------
// avp_lane: one channel lane of the pooling datapath
// Column accumulator memory with read-modify-write, window average by
// reciprocal multiply, and ReLU / h-swish activation.
// ----------------------------------------------------------------------------
`default_nettype none

module avp_lane
    import avp_pkg::*;
#(
    parameter int POOL_SIZE = AVP_POOL_SIZE,
    parameter int MAX_COLS  = AVP_MAX_COLS
) (
    input  logic                     i_clk,
    input  t_lane_ctl                i_ctl,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] i_rd_addr,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] i_wr_addr,
    input  logic signed [DATA_W-1:0] i_pix,
    input  t_act_mode                i_mode,
    input  logic                     i_keep,
    output logic signed [DATA_W-1:0] o_res
);

    localparam int WIN_AREA = POOL_SIZE * POOL_SIZE;
    localparam int RCP_W    = 32;
    localparam int PROD_W   = DATA_W + RCP_W;
    localparam logic [RCP_W-1:0] AVG_RCP = RCP_W'((64'd1 << RCP_W) / WIN_AREA + 1);
    localparam int HSP_W    = DATA_W + HS_Q_W + 1;

    logic signed [DATA_W-1:0] r_mem [MAX_COLS];
    logic signed [DATA_W-1:0] r_rd, r_pix, r_fwd;
    logic signed [DATA_W-1:0] base, sum;

    logic signed [DATA_W-1:0] r_sum;
    logic [DATA_W-1:0]        mag;
    logic [PROD_W-1:0]        avg_prod;

    logic [DATA_W-1:0]        r_qmag;
    logic                     r_neg;
    logic signed [DATA_W-1:0] avg, hs_t;
    logic [HS_D_W-1:0]        hs_d;
    logic [HS_MUL_W-1:0]      hs_qprod;

    logic signed [DATA_W-1:0] r_a;
    logic [HS_Q_W-1:0]        r_q6;
    logic signed [HSP_W-1:0]  hs_p;
    logic signed [DATA_W-1:0] act;

    // accumulator memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd  <= r_mem[i_rd_addr];
            r_pix <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= sum;
            r_fwd            <= sum;
        end
    end

    // stage 1: window sum, wrapping
    assign base = i_ctl.first ? '0 : (i_ctl.use_fwd ? r_fwd : r_rd);
    assign sum  = base + r_pix;

    // stage 2: magnitude over window area, truncating toward zero
    assign mag      = r_sum[DATA_W-1] ? DATA_W'(-r_sum) : DATA_W'(r_sum);
    assign avg_prod = PROD_W'(mag) * PROD_W'(AVG_RCP);

    // stage 3: signed average, h-swish gate d/6
    assign avg  = r_neg ? -$signed(r_qmag) : $signed(r_qmag);
    assign hs_t = avg + HS_THREE;
    always_comb begin
        if (hs_t[DATA_W-1]) begin
            hs_d = '0;
        end else if (hs_t > $signed(DATA_W'(HS_SIX))) begin
            hs_d = HS_SIX;
        end else begin
            hs_d = hs_t[HS_D_W-1:0];
        end
    end
    assign hs_qprod = HS_MUL_W'(hs_d) * HS_RCP_MUL;

    // stage 4: gate times value, floor to format
    assign hs_p = $signed({1'b0, r_q6}) * r_a;

    always_comb begin
        case (i_mode)
            ACT_RELU:   act = r_a[DATA_W-1] ? '0 : r_a;
            ACT_HSWISH: act = hs_p[FRAC_BITS +: DATA_W];
            default:    act = r_a;
        endcase
    end

    assign o_res = i_keep ? act : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_sum  <= sum;
            r_qmag <= avg_prod[PROD_W-1 -: DATA_W];
            r_neg  <= r_sum[DATA_W-1];
            r_a    <= avg;
            r_q6   <= hs_qprod[HS_RCP_SH +: HS_Q_W];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/avp_checker.sv -----
// ----------------------------------------------------------------------------
// avp_checker: port-level checks for the pooling block
// Watches the request and result handshakes of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module avp_checker
    import avp_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_res_word o_out_data
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("held result changed");

    // requests are stalled only behind a held result
    a_stall_cause: assert property (@(posedge i_clk)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("request stalled without a held result");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind avg_pool_with_activation avp_checker u_avp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
